[rtl/core/urbe_pkg.sv]
// Shared constants, codes and types for the serial ring buffer engine.
package urbe_pkg;

  localparam int RX_DEPTH = 256;
  localparam int TX_DEPTH = 256;
  localparam int PORTS    = 2;

  localparam int RAW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TAW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int PIW = (PORTS > 1) ? $clog2(PORTS) : 1;

  localparam int RX_MEM_DEPTH = PORTS * RX_DEPTH;
  localparam int TX_MEM_DEPTH = PORTS * TX_DEPTH;
  localparam int RX_MAW = (RX_MEM_DEPTH > 1) ? $clog2(RX_MEM_DEPTH) : 1;
  localparam int TX_MAW = (TX_MEM_DEPTH > 1) ? $clog2(TX_MEM_DEPTH) : 1;

  localparam int BYTE_MAX = 'hff;

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    KIND_RX_BYTE     = 3'd0,
    KIND_TX_READY    = 3'd1,
    KIND_PEEK        = 3'd2,
    KIND_FORGET      = 3'd3,
    KIND_FRAME_START = 3'd4,
    KIND_FRAME_BYTE  = 3'd5
  } kind_t;

  typedef struct packed {
    logic load;
    logic reduce;
    logic exec;
    logic finish;
  } urbe_cmd_t;

  typedef struct packed {
    logic in_amt_big;
    logic amt_big;
  } urbe_status_t;

endpackage

[rtl/core/urbe_ram.sv]
// Generic simple dual-port RAM with registered read.
module urbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/urbe_ctrl.sv]
// Controller state machine: item handshake, sequencing and result hold.
module urbe_ctrl
  import urbe_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  logic         out_tready,
  output urbe_cmd_t    cmd,
  input  urbe_status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EXEC,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == ST_IDLE) || ((state_r == ST_FINISH) && out_free);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.load   = accept;
    cmd.reduce = (state_r == ST_REDUCE);
    cmd.exec   = (state_r == ST_EXEC);
    cmd.finish = (state_r == ST_FINISH) && out_free;

    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = status.in_amt_big ? ST_REDUCE : ST_EXEC;
        end
      end
      ST_REDUCE: begin
        if (!status.amt_big) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          if (accept) begin
            state_nxt = status.in_amt_big ? ST_REDUCE : ST_EXEC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/urbe_dp.sv]
// Datapath: ring pointers, frame state, ring memories and result register.
module urbe_dp
  import urbe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  urbe_cmd_t             cmd,
  output urbe_status_t          status,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int RSW = RAW + 1;
  localparam int RCW = (RAW > 8) ? RAW : 8;
  localparam int TSW = TAW + 1;
  localparam int TCW = ((TAW > 8) ? TAW : 8) + 1;

  // Per-port control state
  logic [RAW-1:0] rx_head_r [PORTS];
  logic [RAW-1:0] rx_tail_r [PORTS];
  logic           rx_wrap_r [PORTS];
  logic [TAW-1:0] tx_head_r [PORTS];
  logic [TAW-1:0] tx_tail_r [PORTS];
  logic           busy_r    [PORTS];
  logic [7:0]     pend_r    [PORTS];

  // Item and step payload
  logic [2:0]     kind_r;
  logic           port_ok_r;
  logic [PIW-1:0] pidx_r;
  logic [7:0]     data_r;
  logic [7:0]     amt_r;
  logic [7:0]     off_r;
  logic           acc_r, txv_r, byp_r, peek_ok_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [2:0]     in_kind;
  logic           in_port;
  logic           in_port_ok;
  logic [7:0]     in_amount;

  logic [RAW-1:0] rxh, rxt, rxh_nxt, rxt_nxt, peek_pos;
  logic           wrap, wrap_nxt;
  logic [TAW-1:0] txh, txt, txh_nxt, txt_nxt;
  logic           busy, busy_nxt;
  logic [7:0]     pend, pend_nxt;
  logic           acc, txv, byp, pk_ok;
  logic [RSW-1:0] pos_sum;
  logic [TCW-1:0] room_now;

  logic                rx_we, rx_re, tx_we, tx_re;
  logic [RX_MAW-1:0]   rx_base, rx_waddr, rx_raddr;
  logic [TX_MAW-1:0]   tx_base, tx_waddr, tx_raddr;
  logic [7:0]          rx_rdata, tx_rdata;

  logic [7:0] res_peek, res_rx_count, res_tx_free, res_tx_data;
  logic       res_acc, res_txv, res_sending;

  function automatic logic [RAW-1:0] rx_inc(input logic [RAW-1:0] x);
    return (x == RAW'(RX_DEPTH - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [TAW-1:0] tx_inc(input logic [TAW-1:0] x);
    return (x == TAW'(TX_DEPTH - 1)) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [7:0] rx_count(input logic [RAW-1:0] h, input logic [RAW-1:0] t);
    logic [RSW-1:0] s;
    logic [RCW-1:0] u;
    s = RSW'(h) + RSW'(RX_DEPTH) - RSW'(t);
    if (s >= RSW'(RX_DEPTH)) begin
      s = s - RSW'(RX_DEPTH);
    end
    u = RCW'(s[RAW-1:0]);
    return (u > RCW'(BYTE_MAX)) ? 8'(BYTE_MAX) : u[7:0];
  endfunction

  function automatic logic [TCW-1:0] tx_room(input logic [TAW-1:0] h, input logic [TAW-1:0] t,
                                             input logic [7:0] p);
    logic [TSW-1:0] s;
    logic [TCW-1:0] room;
    s = TSW'(h) + TSW'(TX_DEPTH) - TSW'(t);
    if (s >= TSW'(TX_DEPTH)) begin
      s = s - TSW'(TX_DEPTH);
    end
    room = TCW'(TX_DEPTH - 1) - TCW'(s[TAW-1:0]);
    return (room > TCW'(p)) ? room - TCW'(p) : '0;
  endfunction

  assign in_kind    = in_tuser[2:0];
  assign in_port    = in_tuser[3];
  assign in_amount  = in_tdata[15:8];
  assign in_port_ok = (int'(in_port) < PORTS);

  assign status.in_amt_big = (int'(in_amount) >= RX_DEPTH);
  assign status.amt_big    = (int'(off_r) >= RX_DEPTH);

  assign rxh  = rx_head_r[pidx_r];
  assign rxt  = rx_tail_r[pidx_r];
  assign wrap = rx_wrap_r[pidx_r];
  assign txh  = tx_head_r[pidx_r];
  assign txt  = tx_tail_r[pidx_r];
  assign busy = busy_r[pidx_r];
  assign pend = pend_r[pidx_r];

  assign room_now = tx_room(txh, txt, pend);

  // Offset is below the depth here, so one subtract wraps the position
  always_comb begin
    pos_sum = RSW'(rxt) + RSW'(off_r);
    if (pos_sum >= RSW'(RX_DEPTH)) begin
      pos_sum = pos_sum - RSW'(RX_DEPTH);
    end
    peek_pos = pos_sum[RAW-1:0];
  end

  always_comb begin
    rxh_nxt  = rxh;
    rxt_nxt  = rxt;
    wrap_nxt = wrap;
    txh_nxt  = txh;
    txt_nxt  = txt;
    busy_nxt = busy;
    pend_nxt = pend;
    acc      = 1'b0;
    txv      = 1'b0;
    byp      = 1'b0;
    pk_ok    = 1'b0;
    rx_we    = 1'b0;
    rx_re    = 1'b0;
    tx_we    = 1'b0;
    tx_re    = 1'b0;
    if (port_ok_r) begin
      unique case (kind_r)
        KIND_RX_BYTE: begin
          rx_we   = 1'b1;
          rxh_nxt = rx_inc(rxh);
          if (rxh_nxt == '0) begin
            wrap_nxt = 1'b1;
          end
        end
        KIND_TX_READY: begin
          if (busy) begin
            if (txt != txh) begin
              tx_re    = 1'b1;
              txv      = 1'b1;
              txt_nxt  = tx_inc(txt);
              busy_nxt = (tx_inc(txt) != txh);
            end else begin
              busy_nxt = 1'b0;
            end
          end
        end
        KIND_PEEK: begin
          rx_re = 1'b1;
          // Entries are filled in order from reset, so below the write point or after a wrap
          pk_ok = wrap || (peek_pos < rxh);
        end
        KIND_FORGET: begin
          rxt_nxt = peek_pos;
        end
        KIND_FRAME_START: begin
          if ((pend == 8'd0) && (TCW'(amt_r) <= room_now)) begin
            pend_nxt = amt_r;
            acc      = 1'b1;
          end
        end
        KIND_FRAME_BYTE: begin
          if (pend != 8'd0) begin
            tx_we    = 1'b1;
            txh_nxt  = tx_inc(txh);
            pend_nxt = pend - 8'd1;
            acc      = 1'b1;
            if ((pend == 8'd1) && !busy) begin
              if (txt != txh_nxt) begin
                tx_re    = 1'b1;
                txv      = 1'b1;
                byp      = (txt == txh);
                txt_nxt  = tx_inc(txt);
                busy_nxt = (tx_inc(txt) != txh_nxt);
              end else begin
                busy_nxt = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign rx_base  = RX_MAW'(pidx_r) * RX_MAW'(RX_DEPTH);
  assign tx_base  = TX_MAW'(pidx_r) * TX_MAW'(TX_DEPTH);
  assign rx_waddr = rx_base + RX_MAW'(rxh);
  assign rx_raddr = rx_base + RX_MAW'(peek_pos);
  assign tx_waddr = tx_base + TX_MAW'(txh);
  assign tx_raddr = tx_base + TX_MAW'(txt);

  urbe_ram #(
    .WIDTH(8),
    .DEPTH(RX_MEM_DEPTH)
  ) u_rx_ram (
    .clk  (clk),
    .we   (cmd.exec && rx_we),
    .waddr(rx_waddr),
    .wdata(data_r),
    .re   (cmd.exec && rx_re),
    .raddr(rx_raddr),
    .rdata(rx_rdata)
  );

  urbe_ram #(
    .WIDTH(8),
    .DEPTH(TX_MEM_DEPTH)
  ) u_tx_ram (
    .clk  (clk),
    .we   (cmd.exec && tx_we),
    .waddr(tx_waddr),
    .wdata(data_r),
    .re   (cmd.exec && tx_re),
    .raddr(tx_raddr),
    .rdata(tx_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PORTS; i++) begin
        rx_head_r[i] <= '0;
        rx_tail_r[i] <= '0;
        rx_wrap_r[i] <= 1'b0;
        tx_head_r[i] <= '0;
        tx_tail_r[i] <= '0;
        busy_r[i]    <= 1'b0;
        pend_r[i]    <= '0;
      end
    end else if (cmd.exec && port_ok_r) begin
      rx_head_r[pidx_r] <= rxh_nxt;
      rx_tail_r[pidx_r] <= rxt_nxt;
      rx_wrap_r[pidx_r] <= wrap_nxt;
      tx_head_r[pidx_r] <= txh_nxt;
      tx_tail_r[pidx_r] <= txt_nxt;
      busy_r[pidx_r]    <= busy_nxt;
      pend_r[pidx_r]    <= pend_nxt;
    end
  end

  // Result fields, taken from the state as committed by the step
  always_comb begin
    res_acc      = acc_r;
    res_txv      = txv_r;
    res_peek     = (port_ok_r && (kind_r == KIND_PEEK) && peek_ok_r) ? rx_rdata : 8'd0;
    res_tx_data  = txv_r ? (byp_r ? data_r : tx_rdata) : 8'd0;
    res_rx_count = port_ok_r ? rx_count(rxh, rxt) : 8'd0;
    res_tx_free  = 8'd0;
    if (port_ok_r) begin
      res_tx_free = (room_now > TCW'(BYTE_MAX)) ? 8'(BYTE_MAX) : room_now[7:0];
    end
    res_sending  = port_ok_r && busy;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      port_ok_r <= in_port_ok;
      pidx_r    <= in_port_ok ? PIW'(in_port) : '0;
      data_r    <= in_tdata[7:0];
      amt_r     <= in_amount;
      off_r     <= in_amount;
    end else if (cmd.reduce && status.amt_big) begin
      off_r <= off_r - 8'(RX_DEPTH);
    end
    if (cmd.exec) begin
      acc_r     <= acc;
      txv_r     <= txv;
      byp_r     <= byp;
      peek_ok_r <= pk_ok;
    end
    if (cmd.finish) begin
      out_tdata_r <= {5'd0, res_sending, res_tx_data, res_txv, res_tx_free,
                      res_rx_count, res_peek, res_acc};
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

[rtl/core/uart_ring_buffer_engine.sv]
// Top level of the two-port serial ring buffer engine.
// Each port owns a receive ring and a transmit ring held in block RAM.
// Input items arrive on in_tvalid/in_tready: in_tuser carries the kind
// (rx byte, tx ready, peek, forget, frame start, frame byte) and the port,
// in_tdata the byte and the offset, count or frame length.
// Every item gives exactly one result on out_tvalid/out_tready with the
// acceptance flag, peeked byte, receive count, transmit free space, the
// byte handed to the transmitter and the sending flag.
// An item runs through an execute step (pointer update, RAM write and
// read) and a finish step (RAM data and status into the result register),
// and the result register then drives out_tvalid. With rings shorter than
// 256 bytes, an offset of at least one ring length first passes a reduce
// step that takes off one whole ring length at a time.
// The next item is taken in the finish state while the previous result
// still waits; if out_tready stays low the engine holds in finish and
// in_tready stays low until the result register frees up.
// Reset clears all ring pointers and frame state at once; ring contents
// that were never written read as zero.
module uart_ring_buffer_engine
  import urbe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // data_byte[7:0], amount[15:8]
  input  logic [IN_USER_W-1:0]  in_tuser,   // kind[2:0], port[3]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // accepted[0], peek_data[8:1], rx_count[16:9],
                                            // tx_free[24:17], tx_valid[25], tx_data[33:26],
                                            // sending[34], zero[39:35]
);

  urbe_cmd_t    cmd;
  urbe_status_t status;

  urbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .status    (status)
  );

  urbe_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .status   (status),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .out_tdata(out_tdata)
  );

endmodule

[tb/testbench.sv]
// Self-checking testbench for the two-port serial ring buffer engine.
`timescale 1ns / 100ps

package ring_tb_pkg;
  import urbe_pkg::*;

  // Kinds that the block must treat as no-ops
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  typedef struct packed {
    logic       accepted;
    logic [7:0] peek_data;
    logic [7:0] rx_count;
    logic [7:0] tx_free;
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       sending;
  } ring_status_t;

  class ring_scoreboard;
    bit [7:0]     rx_mem [PORTS][RX_DEPTH];
    bit [7:0]     tx_mem [PORTS][TX_DEPTH];
    bit [RAW-1:0] rx_wr [PORTS];
    bit [RAW-1:0] rx_rd [PORTS];
    bit [TAW-1:0] tx_wr [PORTS];
    bit [TAW-1:0] tx_rd [PORTS];
    bit           busy [PORTS];
    bit [7:0]     frame_left [PORTS];
    ring_status_t due_status [$];
    int           n_items, n_checked, n_sent, n_frames, n_overflow, n_fail;

    function int rx_used(bit p);
      bit [RAW-1:0] used;
      used = rx_wr[p] - rx_rd[p];
      return int'(used);
    endfunction

    function int tx_room(bit p);
      bit [TAW-1:0] used;
      int room;
      used = tx_wr[p] - tx_rd[p];
      room = (TX_DEPTH - 1) - int'(used);
      return (room > int'(frame_left[p])) ? room - int'(frame_left[p]) : 0;
    endfunction

    function logic [7:0] sat_byte(int v);
      return (v > BYTE_MAX) ? 8'(BYTE_MAX) : 8'(v);
    endfunction

    // Hand the byte at the read point to the transmitter; stop once drained.
    function bit send_next(bit p, output logic [7:0] byte_out);
      byte_out = '0;
      if (tx_rd[p] == tx_wr[p]) begin
        busy[p] = 1'b0;
        return 1'b0;
      end
      byte_out = tx_mem[p][tx_rd[p]];
      tx_rd[p] = tx_rd[p] + 1'b1;
      busy[p] = (tx_rd[p] != tx_wr[p]);
      return 1'b1;
    endfunction

    function void note_item(logic [2:0] kind, bit p, logic [7:0] data, logic [7:0] amount);
      ring_status_t r;
      logic [7:0]   sent_byte;
      bit           sent;
      bit [RAW-1:0] idx;
      r = '0;
      sent_byte = '0;
      sent = 1'b0;
      n_items++;
      case (kind)
        KIND_RX_BYTE: begin
          if (rx_used(p) == RX_DEPTH - 1) n_overflow++;
          rx_mem[p][rx_wr[p]] = data;
          rx_wr[p] = rx_wr[p] + 1'b1;
        end
        KIND_TX_READY: begin
          if (busy[p]) sent = send_next(p, sent_byte);
        end
        KIND_PEEK: begin
          idx = rx_rd[p] + amount;
          r.peek_data = rx_mem[p][idx];
        end
        KIND_FORGET: rx_rd[p] = rx_rd[p] + amount;
        KIND_FRAME_START: begin
          if (frame_left[p] == 0 && int'(amount) <= tx_room(p)) begin
            frame_left[p] = amount;
            r.accepted = 1'b1;
            n_frames++;
          end
        end
        KIND_FRAME_BYTE: begin
          if (frame_left[p] != 0) begin
            tx_mem[p][tx_wr[p]] = data;
            tx_wr[p] = tx_wr[p] + 1'b1;
            frame_left[p] = frame_left[p] - 1'b1;
            r.accepted = 1'b1;
            // last byte of the frame kicks off an idle transmitter
            if (frame_left[p] == 0 && !busy[p]) sent = send_next(p, sent_byte);
          end
        end
        default: ;
      endcase
      r.rx_count = sat_byte(rx_used(p));
      r.tx_free  = sat_byte(tx_room(p));
      r.tx_valid = sent;
      r.tx_data  = sent ? sent_byte : 8'h00;
      r.sending  = busy[p];
      if (sent) n_sent++;
      due_status.push_back(r);
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        n_fail++;
      end
    endfunction

    function void check_status(logic [OUT_DATA_W-1:0] word);
      ring_status_t want;
      if (due_status.size() == 0) begin
        $error("result 0x%0h arrived with no item outstanding", word);
        n_fail++;
        return;
      end
      want = due_status.pop_front();
      n_checked++;
      compare("accepted",  want.accepted,  word[0]);
      compare("peek_data", want.peek_data, word[8:1]);
      compare("rx_count",  want.rx_count,  word[16:9]);
      compare("tx_free",   want.tx_free,   word[24:17]);
      compare("tx_valid",  want.tx_valid,  word[25]);
      compare("tx_data",   want.tx_data,   word[33:26]);
      compare("sending",   want.sending,   word[34]);
    endfunction
  endclass

endpackage

module testbench;
  import urbe_pkg::*;
  import ring_tb_pkg::*;

  localparam int RANDOM_ITEMS    = 725;
  localparam int HOLD_OFF_AT     = 350;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 20;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // data_byte[7:0], amount[15:8]
  logic [IN_USER_W-1:0]  in_tuser;   // kind[2:0], port[3]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // accepted[0], peek_data[8:1], rx_count[16:9],
                                     // tx_free[24:17], tx_valid[25], tx_data[33:26],
                                     // sending[34], zero[39:35]

  ring_scoreboard sb;
  int             burst_left;
  bit             hold_req;

  uart_ring_buffer_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one item, hold it until taken, then idle if the burst is over.
  task automatic send_item(input logic [2:0] kind, input bit p,
                           input logic [7:0] data, input logic [7:0] amount);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= {p, kind};
    in_tdata  <= {amount, data};
    do @(posedge clk); while (!in_tready);
    sb.note_item(kind, p, data, amount);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 12);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Mostly well-formed traffic: frames get filled, peeks and forgets stay
  // within the waiting bytes; the rest is noise.
  task automatic pick_item(output logic [2:0] kind, output bit p,
                           output logic [7:0] data, output logic [7:0] amount);
    int roll, used, room;
    p = 1'($urandom_range(0, 1));
    if (sb.frame_left[p] == 0 && sb.frame_left[!p] != 0 && $urandom_range(0, 1)) p = !p;
    data   = 8'($urandom);
    amount = 8'($urandom);
    used   = sb.rx_used(p);
    room   = sb.tx_room(p);
    roll   = $urandom_range(0, 99);
    if (sb.frame_left[p] != 0 && roll < 70) begin
      kind = KIND_FRAME_BYTE;
    end else if (roll < 20) begin
      kind = KIND_RX_BYTE;
    end else if (roll < 38) begin
      kind = KIND_TX_READY;
    end else if (roll < 50) begin
      kind = KIND_PEEK;
      if (used > 0 && $urandom_range(0, 3) != 0) amount = 8'($urandom_range(0, used - 1));
    end else if (roll < 60) begin
      kind = KIND_FORGET;
      if ($urandom_range(0, 3) != 0) amount = 8'($urandom_range(0, used));
    end else if (roll < 78) begin
      kind = KIND_FRAME_START;
      case ($urandom_range(0, 19))
        0:       ;  // any length
        1, 2:    amount = (room <= 32) ? 8'(room) : 8'($urandom_range(1, 12));
        3:       amount = (room < BYTE_MAX) ? 8'(room + 1) : 8'(room);
        4:       amount = 8'h00;
        default: amount = 8'($urandom_range(1, 12));
      endcase
    end else if (roll < 92) begin
      kind = KIND_FRAME_BYTE;
    end else if (roll < 97) begin
      kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
    end else begin
      kind = KIND_RX_BYTE;
    end
  endtask

  initial begin
    logic [2:0] kind;
    bit         p;
    logic [7:0] data;
    logic [7:0] amount;
    sb = new;
    burst_left = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty peeks, byte extremes, wrap, overflow, frame corner cases
    send_item(KIND_PEEK,        0, 8'h00, 8'd0);
    send_item(KIND_PEEK,        0, 8'h00, 8'd255);
    send_item(KIND_RX_BYTE,     0, 8'h00, 8'd0);
    send_item(KIND_RX_BYTE,     0, 8'hff, 8'd0);
    send_item(KIND_RX_BYTE,     1, 8'ha5, 8'd0);
    send_item(KIND_PEEK,        0, 8'h00, 8'd1);
    send_item(KIND_FORGET,      1, 8'h00, 8'd255);
    // step the read point past the write point so the ring looks full,
    // then one more byte wraps it to empty
    send_item(KIND_FORGET,      0, 8'h00, 8'd3);
    send_item(KIND_RX_BYTE,     0, 8'h3c, 8'd0);
    send_item(KIND_FRAME_START, 0, 8'h00, 8'd0);
    send_item(KIND_FRAME_BYTE,  0, 8'h11, 8'd0);
    send_item(KIND_TX_READY,    0, 8'h00, 8'd0);
    send_item(KIND_FRAME_START, 1, 8'h00, 8'd3);
    send_item(KIND_FRAME_START, 1, 8'h00, 8'd2);
    send_item(KIND_FRAME_BYTE,  1, 8'h00, 8'd0);
    send_item(KIND_FRAME_BYTE,  1, 8'hff, 8'd0);
    send_item(KIND_FRAME_BYTE,  1, 8'h5a, 8'd0);
    send_item(KIND_FRAME_START, 1, 8'h00, 8'd255);
    send_item(KIND_TX_READY,    1, 8'h00, 8'd0);
    send_item(KIND_FRAME_START, 1, 8'h00, 8'd2);
    send_item(KIND_FRAME_BYTE,  1, 8'h77, 8'd0);
    send_item(KIND_TX_READY,    1, 8'h00, 8'd0);
    send_item(KIND_TX_READY,    1, 8'h00, 8'd0);
    send_item(KIND_TX_READY,    1, 8'h00, 8'd0);
    send_item(KIND_FRAME_BYTE,  1, 8'h88, 8'd0);
    send_item(KIND_SPARE_A,     0, 8'hff, 8'hff);
    send_item(KIND_SPARE_B,     1, 8'hff, 8'hff);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_OFF_AT) hold_req = 1'b1;
      pick_item(kind, p, data, amount);
      send_item(kind, p, data, amount);
    end
    in_tvalid <= 1'b0;

    while (sb.due_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items, checked %0d results: %0d frames taken, %0d bytes sent,",
             sb.n_items, sb.n_checked, sb.n_frames, sb.n_sent);
    $display("%0d receive overflows, one long output stall with input back-pressure.",
             sb.n_overflow);
    if (sb.n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side: stall in segments of its own, plus one long hold-off on request.
  initial begin
    int mode;
    int seg;
    hold_req = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 2);
      seg  = $urandom_range(1, 40);
      for (int n = 0; n < seg; n++) begin
        @(posedge clk);
        if (hold_req) begin
          out_tready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_status(out_tdata);
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[uart_ring_buffer_engine.f]
rtl/core/urbe_pkg.sv
rtl/core/urbe_ram.sv
rtl/core/urbe_ctrl.sv
rtl/core/urbe_dp.sv
rtl/core/uart_ring_buffer_engine.sv
tb/testbench.sv
